@@ sv/utf8_stream_validator_core_defines.svh @@
// assertion macros used by the core rtl file
`ifndef UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, off while reset is low
`define U8SV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// clocked check, also during reset
`define U8SV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define U8SV_ASSERT(lbl, prop, msg)
`define U8SV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/utf8sv_pkg.sv @@
`default_nettype none

package utf8sv_pkg;

  // byte bounds used by the decoder
  localparam logic [7:0] AsciiHi   = 8'd127;
  localparam logic [7:0] Lead2Lo   = 8'd194;
  localparam logic [7:0] Lead2Hi   = 8'd223;
  localparam logic [7:0] LeadE0    = 8'd224;
  localparam logic [7:0] LeadED    = 8'd237;
  localparam logic [7:0] LeadF0    = 8'd240;
  localparam logic [7:0] LeadF4    = 8'd244;
  localparam logic [7:0] ContLo    = 8'd128;
  localparam logic [7:0] ContHi    = 8'd191;
  localparam logic [7:0] ContA0    = 8'd160;
  localparam logic [7:0] Cont9F    = 8'd159;
  localparam logic [7:0] Cont90    = 8'd144;
  localparam logic [7:0] Cont8F    = 8'd143;

  localparam int unsigned DataW    = 8;
  localparam int unsigned OutDataW = 8;

  // decoder position inside a multi-byte sequence
  typedef enum logic [7:0] {
    ST_START = 8'b0000_0001,  // between characters
    ST_TAIL1 = 8'b0000_0010,  // one continuation byte left
    ST_E0    = 8'b0000_0100,  // after e0, needs a0..bf
    ST_TAIL2 = 8'b0000_1000,  // two continuation bytes left
    ST_ED    = 8'b0001_0000,  // after ed, needs 80..9f
    ST_F0    = 8'b0010_0000,  // after f0, needs 90..bf
    ST_TAIL3 = 8'b0100_0000,  // three continuation bytes left
    ST_F4    = 8'b1000_0000   // after f4, needs 80..8f
  } dfa_state_e;

  // decoder step result
  typedef struct packed {
    logic       err;
    dfa_state_e nxt;
  } dfa_step_t;

endpackage

`default_nettype wire

@@ sv/utf8sv_dfa.sv @@
`default_nettype none

module utf8sv_dfa import utf8sv_pkg::*; (
  input  dfa_state_e       state_i,
  input  logic [DataW-1:0] byte_i,
  output dfa_step_t        step_o
);

  logic is_cont;

  assign is_cont = (byte_i >= ContLo) && (byte_i <= ContHi);

  // one decoder step, err set for any byte the current state rejects
  always_comb begin
    step_o.err = 1'b0;
    step_o.nxt = ST_START;
    unique case (state_i)
      ST_START: begin
        if (byte_i != 8'd0 && byte_i <= AsciiHi) begin
          step_o.nxt = ST_START;
        end else if (byte_i >= Lead2Lo && byte_i <= Lead2Hi) begin
          step_o.nxt = ST_TAIL1;
        end else if (byte_i == LeadE0) begin
          step_o.nxt = ST_E0;
        end else if (byte_i == LeadED) begin
          step_o.nxt = ST_ED;
        end else if (byte_i > LeadE0 && byte_i < LeadF0) begin
          step_o.nxt = ST_TAIL2;
        end else if (byte_i == LeadF0) begin
          step_o.nxt = ST_F0;
        end else if (byte_i > LeadF0 && byte_i < LeadF4) begin
          step_o.nxt = ST_TAIL3;
        end else if (byte_i == LeadF4) begin
          step_o.nxt = ST_F4;
        end else begin
          step_o.err = 1'b1;
        end
      end
      ST_TAIL1: begin
        step_o.nxt = ST_START;
        step_o.err = !is_cont;
      end
      ST_E0: begin
        step_o.nxt = ST_TAIL1;
        step_o.err = !(byte_i >= ContA0 && byte_i <= ContHi);
      end
      ST_TAIL2: begin
        step_o.nxt = ST_TAIL1;
        step_o.err = !is_cont;
      end
      ST_ED: begin
        step_o.nxt = ST_TAIL1;
        step_o.err = !(byte_i >= ContLo && byte_i <= Cont9F);
      end
      ST_F0: begin
        step_o.nxt = ST_TAIL2;
        step_o.err = !(byte_i >= Cont90 && byte_i <= ContHi);
      end
      ST_TAIL3: begin
        step_o.nxt = ST_TAIL2;
        step_o.err = !is_cont;
      end
      ST_F4: begin
        step_o.nxt = ST_TAIL2;
        step_o.err = !(byte_i >= ContLo && byte_i <= Cont8F);
      end
      default: begin
        step_o.err = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/utf8_stream_validator_core.sv @@
// channel   dir  tdata                  tuser         tlast
// s_axis    in   [7:0] data_byte        [0] no_byte   last_byte
// m_axis    out  [0] message_valid      -             -
//
// one byte per clock while no last beat waits; each beat is held in the
// input register, and the decoder step sits between it and the verdict register.
// only the last beat of a message yields a verdict beat.
// reset clears both valid flags, the decoder state and the sticky error.
// a last beat waits in the input register while a verdict is still pending
// downstream; other beats never wait.
`default_nettype none
`include "utf8_stream_validator_core_defines.svh"

module utf8_stream_validator_core import utf8sv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [DataW-1:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                s_axis_tlast_i,   // last_byte
  input  logic                s_axis_tuser_i,   // [0] no_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [0] message_valid, [7:1] zero
);

  logic             in_valid_q;
  logic [DataW-1:0] in_byte_q;
  logic             in_last_q;
  logic             in_empty_q;
  logic             in_adv;

  dfa_state_e       dfa_q, dfa_d;
  logic             err_q, err_d;
  dfa_step_t        step;

  logic             out_valid_q, out_valid_d;
  logic             verdict_q, verdict_d;
  logic             out_load;

  // input register advances unless a last beat meets a full verdict slot
  assign in_adv          = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || in_adv;
  assign out_load        = in_adv && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_last_q  <= s_axis_tlast_i;
      in_empty_q <= s_axis_tuser_i;
    end
  end

  utf8sv_dfa u_dfa (
    .state_i (dfa_q),
    .byte_i  (in_byte_q),
    .step_o  (step)
  );

  // decoder update, verdict and end-of-message restart
  always_comb begin
    logic       err_n;
    dfa_state_e dfa_n;
    err_n       = err_q;
    dfa_n       = dfa_q;
    if (!in_empty_q && !err_q) begin
      if (step.err) begin
        err_n = 1'b1;
      end else begin
        dfa_n = step.nxt;
      end
    end
    verdict_d = !err_n && (dfa_n == ST_START);
    dfa_d     = dfa_q;
    err_d     = err_q;
    if (in_adv) begin
      dfa_d = in_last_q ? ST_START : dfa_n;
      err_d = in_last_q ? 1'b0 : err_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfa_q <= ST_START;
      err_q <= 1'b0;
    end else begin
      dfa_q <= dfa_d;
      err_q <= err_d;
    end
  end

  // verdict register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= verdict_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-1){1'b0}}, verdict_q};

  // checks
  `U8SV_ASSERT(a_restart_after_last, out_load |=> (dfa_q == ST_START && !err_q),
               "decoder not restarted after last beat")
  `U8SV_ASSERT(a_frozen_on_error, (err_q && !out_load) |=> (err_q && $stable(dfa_q)),
               "decoder state moved after an error")
  `U8SV_ASSERT(a_no_verdict_overrun, out_load |-> (!out_valid_q || m_axis_tready_i),
               "verdict overwritten before it was taken")

endmodule

`default_nettype wire

@@ verif/tb_utf8_stream_validator_core.sv @@
`default_nettype none

module tb_utf8_stream_validator_core import utf8sv_pkg::*;;

  localparam int unsigned RandItems  = 900;
  localparam int unsigned CalmItems  = 150;   // closing stretch with no bursts
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned NumRows    = 26;

  // one row of the directed table
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       typed;    // verdict below is written out, not predicted
    logic       verdict;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [DataW-1:0]    s_axis_tdata_i = '0;   // [7:0] data_byte
  logic                s_axis_tlast_i = 1'b0; // last_byte
  logic                s_axis_tuser_i = 1'b0; // [0] no_byte
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;        // [0] message_valid, [7:1] zero

  // written-out verdict travelling with the beat
  logic row_typed = 1'b0;
  logic row_verdict = 1'b0;

  logic bursts_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned verdicts_ok = 0;
  int unsigned verdicts_bad = 0;

  // predictor state
  dfa_state_e utf_pos = ST_START;
  logic       utf_err = 1'b0;
  dfa_step_t  step_r;
  logic       verdict_now;

  logic verdict_q[$];
  logic [7:0] msg_bytes[$];

  wire s_fire = s_axis_tvalid_i && s_axis_tready_o;
  wire m_fire = m_axis_tvalid_o && m_axis_tready_i;

  dir_row_t dir_rows [NumRows] = '{
    // empty message
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
    // top ascii byte alone
    '{8'h7f, 1'b1, 1'b0, 1'b1, 1'b1},
    // nul byte
    '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0},
    // 0xff is never legal
    '{8'hff, 1'b1, 1'b0, 1'b1, 1'b0},
    // continuation without a lead
    '{8'h80, 1'b1, 1'b0, 1'b1, 1'b0},
    // smallest two-byte form
    '{8'hc2, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b1, 1'b1},
    // overlong three-byte form
    '{8'he0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h9f, 1'b1, 1'b0, 1'b1, 1'b0},
    // surrogate
    '{8'hed, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'ha0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b1, 1'b0},
    // code point above 10ffff
    '{8'hf4, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b1, 1'b0},
    // four-byte sequence cut short
    '{8'hf0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b1, 1'b0},
    // empty item in the middle of a sequence
    '{8'he1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b1, 1'b0, 1'b0, 1'b0},
    // good byte after an error, closed by an empty last item
    '{8'hff, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}
  };

  utf8_stream_validator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock, period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one decoder step: next position, or an error for a rejected byte
  function automatic dfa_step_t decode_step(dfa_state_e pos, logic [7:0] b);
    dfa_step_t r;
    r.err = 1'b0;
    r.nxt = ST_START;
    case (pos)
      ST_START: begin
        if (b >= 8'd1 && b <= AsciiHi) r.nxt = ST_START;
        else if (b >= Lead2Lo && b <= Lead2Hi) r.nxt = ST_TAIL1;
        else if (b == LeadE0) r.nxt = ST_E0;
        else if (b == LeadED) r.nxt = ST_ED;
        else if (b > LeadE0 && b < LeadF0) r.nxt = ST_TAIL2;
        else if (b == LeadF0) r.nxt = ST_F0;
        else if (b > LeadF0 && b < LeadF4) r.nxt = ST_TAIL3;
        else if (b == LeadF4) r.nxt = ST_F4;
        else r.err = 1'b1;
      end
      ST_TAIL1: begin
        r.nxt = ST_START;
        r.err = !(b >= ContLo && b <= ContHi);
      end
      ST_E0: begin
        r.nxt = ST_TAIL1;
        r.err = !(b >= ContA0 && b <= ContHi);
      end
      ST_TAIL2: begin
        r.nxt = ST_TAIL1;
        r.err = !(b >= ContLo && b <= ContHi);
      end
      ST_ED: begin
        r.nxt = ST_TAIL1;
        r.err = !(b >= ContLo && b <= Cont9F);
      end
      ST_F0: begin
        r.nxt = ST_TAIL2;
        r.err = !(b >= Cont90 && b <= ContHi);
      end
      ST_TAIL3: begin
        r.nxt = ST_TAIL2;
        r.err = !(b >= ContLo && b <= ContHi);
      end
      default: begin
        r.nxt = ST_TAIL2;
        r.err = !(b >= ContLo && b <= Cont8F);
      end
    endcase
    return r;
  endfunction

  // predict on input beats, check verdict beats
  always @(posedge clk_i) begin
    if (rst_ni && s_fire) begin
      if (!s_axis_tuser_i && !utf_err) begin
        step_r = decode_step(utf_pos, s_axis_tdata_i);
        if (step_r.err) utf_err = 1'b1;
        else utf_pos = step_r.nxt;
      end
      if (s_axis_tlast_i) begin
        verdict_now = !utf_err && (utf_pos == ST_START);
        verdict_q.push_back(row_typed ? row_verdict : verdict_now);
        utf_pos = ST_START;
        utf_err = 1'b0;
      end
    end
    if (rst_ni && m_fire) begin
      if (verdict_q.size() == 0) begin
        $error("verdict beat with none expected: message_valid %0b", m_axis_tdata_o[0]);
        errors++;
      end else begin
        verdict_now = verdict_q.pop_front();
        if (m_axis_tdata_o[0] !== verdict_now) begin
          $error("message_valid: expected %0b, got %0b", verdict_now, m_axis_tdata_o[0]);
          errors++;
        end
        if (m_axis_tdata_o[OutDataW-1:1] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata_o[OutDataW-1:1]);
          errors++;
        end
        if (verdict_now) verdicts_ok++;
        else verdicts_bad++;
      end
    end
  end

  // receiver with random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_fire || m_fire) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // drive one input beat and wait for it to be taken
  task automatic send_beat(logic [7:0] data, logic last, logic empty,
                           logic typed, logic verdict);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tlast_i  <= last;
    s_axis_tuser_i  <= empty;
    row_typed       <= typed;
    row_verdict     <= verdict;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_sent++;
    if (last) messages_sent++;
  endtask

  // hold off until every pending verdict has come back
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(ContHi, ContLo));
  endfunction

  // one well-formed character of random class
  task automatic append_char();
    logic [7:0] lead;
    case ($urandom_range(0, 7))
      0: msg_bytes.push_back(8'($urandom_range(AsciiHi, 1)));
      1: begin
        msg_bytes.push_back(8'($urandom_range(Lead2Hi, Lead2Lo)));
        msg_bytes.push_back(cont_byte());
      end
      2: begin
        msg_bytes.push_back(LeadE0);
        msg_bytes.push_back(8'($urandom_range(ContHi, ContA0)));
        msg_bytes.push_back(cont_byte());
      end
      3: begin
        lead = 8'($urandom_range(LeadF0 - 2, LeadE0 + 1));
        if (lead == LeadED) lead = LeadF0 - 8'd1;
        msg_bytes.push_back(lead);
        msg_bytes.push_back(cont_byte());
        msg_bytes.push_back(cont_byte());
      end
      4: begin
        msg_bytes.push_back(LeadED);
        msg_bytes.push_back(8'($urandom_range(Cont9F, ContLo)));
        msg_bytes.push_back(cont_byte());
      end
      5: begin
        msg_bytes.push_back(LeadF0);
        msg_bytes.push_back(8'($urandom_range(ContHi, Cont90)));
        msg_bytes.push_back(cont_byte());
        msg_bytes.push_back(cont_byte());
      end
      6: begin
        msg_bytes.push_back(8'($urandom_range(LeadF4 - 1, LeadF0 + 1)));
        repeat (3) msg_bytes.push_back(cont_byte());
      end
      default: begin
        msg_bytes.push_back(LeadF4);
        msg_bytes.push_back(8'($urandom_range(Cont8F, ContLo)));
        msg_bytes.push_back(cont_byte());
        msg_bytes.push_back(cont_byte());
      end
    endcase
  endtask

  // mostly well-formed text, some corrupted, cut short or pure noise
  task automatic build_message();
    msg_bytes.delete();
    repeat ($urandom_range(0, 6)) append_char();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: if (msg_bytes.size() > 0)
             msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
        1: if (msg_bytes.size() > 0) void'(msg_bytes.pop_back());
        default: begin
          msg_bytes.delete();
          repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
        end
      endcase
    end
  endtask

  // send the built message, now and then with stray empty items
  task automatic send_message();
    int n;
    logic end_marker;
    n = msg_bytes.size();
    end_marker = (n == 0) || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
      send_beat(msg_bytes[i], !end_marker && (i == n - 1), 1'b0, 1'b0, 1'b0);
    end
    if (end_marker) send_beat(8'($urandom), 1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  // stimulus
  initial begin
    int unsigned rand_start;
    logic paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i])
      send_beat(dir_rows[i].data, dir_rows[i].last, dir_rows[i].empty,
                dir_rows[i].typed, dir_rows[i].verdict);

    // random messages
    rand_start = beats_sent;
    while (beats_sent - rand_start < RandItems) begin
      if (beats_sent - rand_start >= RandItems - CalmItems) bursts_on = 1'b0;
      if ((!paused && beats_sent - rand_start >= RandItems / 2) ||
          $urandom_range(0, 24) == 0) begin
        wait_drained();
        paused = 1'b1;
      end
      build_message();
      send_message();
    end

    // close out
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("sent %0d beats in %0d messages, incl. empty and stray empty items",
             beats_sent, messages_sent);
    $display("checked %0d verdicts: %0d valid, %0d invalid",
             verdicts_ok + verdicts_bad, verdicts_ok, verdicts_bad);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/utf8sv_pkg.sv
sv/utf8sv_dfa.sv
sv/utf8_stream_validator_core.sv
verif/tb_utf8_stream_validator_core.sv
